// ===== sv/mpwr_pkg.sv =====
// Shared types, widths and codes of the Manchester pulse-width receiver.
// Used by the interfaces, the step logic and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpwr_pkg;

  // Frame store capacity and the count width derived from it.
  localparam int MaxFrameBytes = 64;
  localparam int CountW        = $clog2(MaxFrameBytes + 1);

  // Field widths fixed by the line format.
  localparam int TicksW    = 10;
  localparam int NominalW  = 9;
  localparam int ExpectW   = 9;
  localparam int PositionW = 6;
  localparam int LengthW   = 7;
  localparam int CmpW      = 10;
  localparam int PhaseW    = 3;

  // Constant added to the first byte to form the frame length.
  localparam logic [ExpectW-1:0] LengthBias = 9'd3;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgTimeout     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFirstStart  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSecondStart = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgThirdStart  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFourthStart = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLongPulse   = 3'd5;

  localparam logic [TicksW-1:0]   TimeoutReset     = 10'd200;
  localparam logic [NominalW-1:0] FirstStartReset  = 9'd80;
  localparam logic [NominalW-1:0] SecondStartReset = 9'd80;
  localparam logic [NominalW-1:0] ThirdStartReset  = 9'd40;
  localparam logic [NominalW-1:0] FourthStartReset = 9'd40;
  localparam logic [TicksW-1:0]   LongPulseReset   = 10'd20;

  // Receive phase codes.
  localparam logic [PhaseW-1:0] PhIdle = 3'd0;
  localparam logic [PhaseW-1:0] PhPre1 = 3'd1;
  localparam logic [PhaseW-1:0] PhPre2 = 3'd2;
  localparam logic [PhaseW-1:0] PhPre3 = 3'd3;
  localparam logic [PhaseW-1:0] PhPre4 = 3'd4;
  localparam logic [PhaseW-1:0] PhSync = 3'd5;
  localparam logic [PhaseW-1:0] PhData = 3'd6;

  // Timing settings as seen by the step logic.
  typedef struct packed {
    logic [TicksW-1:0]   timeout_ticks;
    logic [NominalW-1:0] first_start_ticks;
    logic [NominalW-1:0] second_start_ticks;
    logic [NominalW-1:0] third_start_ticks;
    logic [NominalW-1:0] fourth_start_ticks;
    logic [TicksW-1:0]   long_pulse_ticks;
  } cfg_t;

  // Receiver state carried from edge to edge.
  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [2:0]         bit_position;
    logic [7:0]         partial_byte;
    logic               odd_half;
    logic [CountW-1:0]  stored_count;
    logic [ExpectW-1:0] expected_count;
  } rx_state_t;

  // One result word.
  typedef struct packed {
    logic                 byte_valid;
    logic [7:0]           data_byte;
    logic [PositionW-1:0] byte_position;
    logic                 frame_done;
    logic [LengthW-1:0]   frame_length;
    logic                 timed_out;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/mpwr_if.sv =====
// Handshake interfaces of the receiver: edge words in, result words out,
// and the configuration write channel. Depends on mpwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mpwr_edge_if;
  logic                        valid;
  logic                        ready;
  logic                        line_level;
  logic [mpwr_pkg::TicksW-1:0] interval_ticks;

  modport source (output valid, output line_level, output interval_ticks, input ready);
  modport sink   (input valid, input line_level, input interval_ticks, output ready);
endinterface

interface mpwr_result_if;
  logic                           valid;
  logic                           ready;
  logic                           byte_valid;
  logic [7:0]                     data_byte;
  logic [mpwr_pkg::PositionW-1:0] byte_position;
  logic                           frame_done;
  logic [mpwr_pkg::LengthW-1:0]   frame_length;
  logic                           timed_out;

  modport source (output valid, output byte_valid, output data_byte, output byte_position,
                  output frame_done, output frame_length, output timed_out, input ready);
  modport sink   (input valid, input byte_valid, input data_byte, input byte_position,
                  input frame_done, input frame_length, input timed_out, output ready);
endinterface

interface mpwr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mpwr_pkg::CfgIdxW-1:0]  index;
  logic [mpwr_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/manchester_pulse_width_receiver_top.sv =====
// Top level of the Manchester pulse-width receiver: input register, state,
// settings and result register. Depends on mpwr_pkg, mpwr_if and mpwr_step.
`timescale 1ns / 1ps
`default_nettype none

// The receiver takes one line edge word per clock unless stalled (level after
// the edge and ticks since the previous edge) and gives at most one result
// word per edge: a completed data byte with its position, the end of a frame,
// or both. An edge word is registered in the input register when accepted,
// decoded by the single decode step, and its result word is registered in
// the result register; a new edge can be accepted every clock unless stalled.
// A waiting result word stalls only edges that would produce another result.
// Settings are written over the configuration channel, which is always
// ready; the user must write them only while the receiver is idle, as the
// block itself does not enforce this. There is no clearing pass after reset.
module manchester_pulse_width_receiver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpwr_edge_if.sink  edge_i,
  mpwr_cfg_if.sink   cfg_i,
  mpwr_result_if.source result_o
);

  mpwr_pkg::cfg_t      cfg_q;
  mpwr_pkg::rx_state_t state_q;
  mpwr_pkg::rx_state_t state_d;
  mpwr_pkg::result_t   res_d;
  mpwr_pkg::result_t   res_q;

  logic                        in_valid_q;
  logic                        in_level_q;
  logic [mpwr_pkg::TicksW-1:0] in_ticks_q;
  logic                        out_valid_q;
  logic                        has_result;
  logic                        out_free;
  logic                        advance;
  logic                        in_accept;

  // Settings registers, written by index.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks      <= mpwr_pkg::TimeoutReset;
      cfg_q.first_start_ticks  <= mpwr_pkg::FirstStartReset;
      cfg_q.second_start_ticks <= mpwr_pkg::SecondStartReset;
      cfg_q.third_start_ticks  <= mpwr_pkg::ThirdStartReset;
      cfg_q.fourth_start_ticks <= mpwr_pkg::FourthStartReset;
      cfg_q.long_pulse_ticks   <= mpwr_pkg::LongPulseReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mpwr_pkg::CfgTimeout:     cfg_q.timeout_ticks      <= cfg_i.data;
        mpwr_pkg::CfgFirstStart:  cfg_q.first_start_ticks  <= cfg_i.data[mpwr_pkg::NominalW-1:0];
        mpwr_pkg::CfgSecondStart: cfg_q.second_start_ticks <= cfg_i.data[mpwr_pkg::NominalW-1:0];
        mpwr_pkg::CfgThirdStart:  cfg_q.third_start_ticks  <= cfg_i.data[mpwr_pkg::NominalW-1:0];
        mpwr_pkg::CfgFourthStart: cfg_q.fourth_start_ticks <= cfg_i.data[mpwr_pkg::NominalW-1:0];
        mpwr_pkg::CfgLongPulse:   cfg_q.long_pulse_ticks   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Decode step for the registered edge word.
  mpwr_step u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .level_i      (in_level_q),
    .ticks_i      (in_ticks_q),
    .state_o      (state_d),
    .result_o     (res_d),
    .has_result_o (has_result)
  );

  // The registered edge moves on unless its result finds the output slot full.
  assign out_free     = !out_valid_q || result_o.ready;
  assign advance      = in_valid_q && (!has_result || out_free);
  assign edge_i.ready = !in_valid_q || advance;
  assign in_accept    = edge_i.valid && edge_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (edge_i.ready) begin
      in_valid_q <= edge_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_level_q <= edge_i.line_level;
      in_ticks_q <= edge_i.interval_ticks;
    end
  end

  // Receiver state, updated once per decoded edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.byte_valid    = res_q.byte_valid;
  assign result_o.data_byte     = res_q.data_byte;
  assign result_o.byte_position = res_q.byte_position;
  assign result_o.frame_done    = res_q.frame_done;
  assign result_o.frame_length  = res_q.frame_length;
  assign result_o.timed_out     = res_q.timed_out;

endmodule

`default_nettype wire

// ===== sv/mpwr_step.sv =====
// Per-edge decode logic: preamble recognition, Manchester bit recovery,
// byte assembly and frame end detection. Depends on mpwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpwr_step (
  input  mpwr_pkg::cfg_t              cfg_i,
  input  mpwr_pkg::rx_state_t         state_i,
  input  logic                        level_i,
  input  logic [mpwr_pkg::TicksW-1:0] ticks_i,
  output mpwr_pkg::rx_state_t         state_o,
  output mpwr_pkg::result_t           result_o,
  output logic                        has_result_o
);

  // A width is inside the window when it lies strictly between T and 2T.
  function automatic logic in_window(logic [mpwr_pkg::TicksW-1:0]   t,
                                     logic [mpwr_pkg::NominalW-1:0] nominal);
    logic [mpwr_pkg::TicksW:0] t_ext;
    logic [mpwr_pkg::TicksW:0] lo;
    logic [mpwr_pkg::TicksW:0] hi;
    t_ext = {1'b0, t};
    lo    = (mpwr_pkg::TicksW + 1)'(nominal);
    hi    = {lo[mpwr_pkg::TicksW-1:0], 1'b0};
    return (t_ext > lo) && (t_ext < hi);
  endfunction

  logic [mpwr_pkg::PhaseW-1:0] phase;
  logic                        take;
  logic                        data_phase;
  logic                        long_pulse;
  logic [7:0]                  merged_byte;
  mpwr_pkg::rx_state_t         nxt;
  mpwr_pkg::result_t           res;

  always_comb begin
    nxt         = state_i;
    res         = '0;
    take        = 1'b0;
    data_phase  = 1'b0;
    long_pulse  = ticks_i > cfg_i.long_pulse_ticks;
    phase       = state_i.phase;

    // Timeout aborts any reception; a frame in progress is reported.
    if (state_i.phase != mpwr_pkg::PhIdle && ticks_i > cfg_i.timeout_ticks) begin
      if (state_i.phase == mpwr_pkg::PhData) begin
        res.frame_done   = 1'b1;
        res.timed_out    = 1'b1;
        res.frame_length = mpwr_pkg::LengthW'(state_i.stored_count);
      end
      phase = mpwr_pkg::PhIdle;
    end else if (level_i && phase == mpwr_pkg::PhIdle) begin
      phase = mpwr_pkg::PhPre1;
    end

    // A falling edge with a good first pulse restarts the preamble from anywhere.
    if (!level_i && in_window(ticks_i, cfg_i.first_start_ticks)) begin
      phase = mpwr_pkg::PhPre2;
    end

    // Remaining preamble pulses, the sync edge and the data phase.
    if (level_i && phase == mpwr_pkg::PhPre2) begin
      phase = in_window(ticks_i, cfg_i.second_start_ticks) ? mpwr_pkg::PhPre3
                                                           : mpwr_pkg::PhIdle;
    end else begin
      unique case (phase)
        mpwr_pkg::PhPre3: begin
          phase = in_window(ticks_i, cfg_i.third_start_ticks) ? mpwr_pkg::PhPre4
                                                              : mpwr_pkg::PhIdle;
        end
        mpwr_pkg::PhPre4: begin
          phase = in_window(ticks_i, cfg_i.fourth_start_ticks) ? mpwr_pkg::PhSync
                                                               : mpwr_pkg::PhIdle;
        end
        mpwr_pkg::PhSync: begin
          nxt.bit_position = '0;
          nxt.odd_half     = 1'b0;
          nxt.partial_byte = '0;
          nxt.stored_count = '0;
          phase            = mpwr_pkg::PhData;
        end
        mpwr_pkg::PhData: begin
          // A long pulse or the second short pulse in a row carries a bit.
          data_phase   = 1'b1;
          take         = long_pulse || state_i.odd_half;
          nxt.odd_half = !long_pulse && !state_i.odd_half;
        end
        default: begin
        end
      endcase
    end

    // Pack the bit, least significant first, and store finished bytes.
    merged_byte                       = state_i.partial_byte;
    merged_byte[state_i.bit_position] = state_i.partial_byte[state_i.bit_position] | level_i;
    if (take) begin
      if (state_i.bit_position == 3'd7) begin
        nxt.bit_position = '0;
        nxt.partial_byte = '0;
        if (state_i.stored_count == '0) begin
          nxt.expected_count = mpwr_pkg::ExpectW'(merged_byte) + mpwr_pkg::LengthBias;
        end
        if (state_i.stored_count < mpwr_pkg::CountW'(mpwr_pkg::MaxFrameBytes)) begin
          res.byte_valid    = 1'b1;
          res.data_byte     = merged_byte;
          res.byte_position = mpwr_pkg::PositionW'(state_i.stored_count);
          nxt.stored_count  = state_i.stored_count + mpwr_pkg::CountW'(1);
        end
      end else begin
        nxt.bit_position = state_i.bit_position + 3'd1;
        nxt.partial_byte = merged_byte;
      end
    end

    // The frame ends once the stored count reaches the announced length.
    if (data_phase && nxt.expected_count != '0 &&
        mpwr_pkg::CmpW'(nxt.stored_count) >= mpwr_pkg::CmpW'(nxt.expected_count)) begin
      res.frame_done   = 1'b1;
      res.timed_out    = 1'b0;
      res.frame_length = mpwr_pkg::LengthW'(nxt.stored_count);
      nxt.stored_count = '0;
      phase            = mpwr_pkg::PhIdle;
    end

    nxt.phase = phase;
  end

  assign state_o      = nxt;
  assign result_o     = res;
  assign has_result_o = res.byte_valid || res.frame_done;

endmodule

`default_nettype wire

// ===== bench/mpwr_frame_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Manchester pulse-width receiver. It predicts result words from the
// accepted edge words and settings, and compares them with the delivered words.
// Depends on mpwr_pkg and the channel interfaces of mpwr_if.

module mpwr_frame_checker
  import mpwr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mpwr_edge_if        line_i,
  mpwr_cfg_if         cfg_i,
  mpwr_result_if      result_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  // Settings after reset, kept here on purpose so that the reset values get checked too.
  localparam int unsigned GapReset     = 200;
  localparam int unsigned Start1Reset  = 80;
  localparam int unsigned Start2Reset  = 80;
  localparam int unsigned Start3Reset  = 40;
  localparam int unsigned Start4Reset  = 40;
  localparam int unsigned LongReset    = 20;
  localparam logic [8:0]  LengthOffset = 9'd3;

  typedef enum logic [2:0] {
    RxIdle, RxPre1, RxPre2, RxPre3, RxPre4, RxSync, RxData
  } rx_phase_e;

  // Settings mirror.
  int unsigned gap_limit;
  int unsigned start_nom [4];
  int unsigned long_limit;

  // Receiver state mirror.
  rx_phase_e   rx_phase;
  logic [2:0]  bit_idx;
  logic [7:0]  byte_acc;
  logic        half_seen;
  int unsigned bytes_stored;
  logic [8:0]  bytes_expected;

  result_t     expected_words [$];
  int unsigned errors = 0;

  function automatic bit in_window(int unsigned ticks, int unsigned nominal);
    return ticks > nominal && ticks < 2 * nominal;
  endfunction

  // Packs one decoded bit, least significant first. Returns 1 when a byte is stored.
  function automatic bit shift_in_bit(input logic level, output logic [7:0] byte_o,
                                      output logic [5:0] pos_o);
    bit kept;
    kept   = 1'b0;
    byte_o = '0;
    pos_o  = '0;
    if (level) byte_acc[bit_idx] = 1'b1;
    if (bit_idx == 3'd7) begin
      bit_idx = '0;
      if (bytes_stored == 0) bytes_expected = {1'b0, byte_acc} + LengthOffset;
      // Bytes past the store capacity vanish without a word.
      if (bytes_stored < MaxFrameBytes) begin
        byte_o = byte_acc;
        pos_o  = bytes_stored[5:0];
        bytes_stored++;
        kept = 1'b1;
      end
      byte_acc = '0;
    end else begin
      bit_idx++;
    end
    return kept;
  endfunction

  // Advances the receiver mirror by one line edge; returns 1 when a word is due.
  function automatic bit decode_edge(input logic level, input int unsigned ticks,
                                     output result_t word);
    bit          got_byte;
    bit          done;
    bit          late;
    logic [7:0]  data;
    logic [5:0]  pos;
    logic [6:0]  len;
    got_byte = 1'b0;
    done     = 1'b0;
    late     = 1'b0;
    data     = '0;
    pos      = '0;
    len      = '0;

    // A long gap aborts everything; only a data frame reports it.
    if (rx_phase != RxIdle && ticks > gap_limit) begin
      if (rx_phase == RxData) begin
        done = 1'b1;
        late = 1'b1;
        len  = bytes_stored[6:0];
      end
      rx_phase = RxIdle;
    end else if (level && rx_phase == RxIdle) begin
      rx_phase = RxPre1;
    end

    // A low edge in the first window restarts the preamble from anywhere.
    if (!level && in_window(ticks, start_nom[0])) rx_phase = RxPre2;

    if (level && rx_phase == RxPre2) begin
      rx_phase = in_window(ticks, start_nom[1]) ? RxPre3 : RxIdle;
    end else if (rx_phase == RxPre3) begin
      rx_phase = in_window(ticks, start_nom[2]) ? RxPre4 : RxIdle;
    end else if (rx_phase == RxPre4) begin
      rx_phase = in_window(ticks, start_nom[3]) ? RxSync : RxIdle;
    end else if (rx_phase == RxSync) begin
      bit_idx      = '0;
      half_seen    = 1'b0;
      byte_acc     = '0;
      bytes_stored = 0;
      rx_phase     = RxData;
    end else if (rx_phase == RxData) begin
      // A long pulse gives a bit at once, short pulses give one bit per pair.
      if (ticks > long_limit) begin
        got_byte  = shift_in_bit(level, data, pos);
        half_seen = 1'b0;
      end else if (half_seen) begin
        half_seen = 1'b0;
        got_byte  = shift_in_bit(level, data, pos);
      end else begin
        half_seen = 1'b1;
      end
      if (bytes_expected != 0 && bytes_stored >= bytes_expected) begin
        done         = 1'b1;
        late         = 1'b0;
        len          = bytes_stored[6:0];
        bytes_stored = 0;
        rx_phase     = RxIdle;
      end
    end

    word.byte_valid    = got_byte;
    word.data_byte     = got_byte ? data : '0;
    word.byte_position = got_byte ? pos : '0;
    word.frame_done    = done;
    word.frame_length  = done ? len : '0;
    word.timed_out     = done && late;
    return got_byte || done;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t got;
    if (!rst_ni) begin
      gap_limit      = GapReset;
      start_nom      = '{Start1Reset, Start2Reset, Start3Reset, Start4Reset};
      long_limit     = LongReset;
      rx_phase       = RxIdle;
      bit_idx        = '0;
      byte_acc       = '0;
      half_seen      = 1'b0;
      bytes_stored   = 0;
      bytes_expected = '0;
      expected_words.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      // Delivered words are compared before this edge's word is predicted.
      if (result_i.valid && result_i.ready) begin
        got.byte_valid    = result_i.byte_valid;
        got.data_byte     = result_i.data_byte;
        got.byte_position = result_i.byte_position;
        got.frame_done    = result_i.frame_done;
        got.frame_length  = result_i.frame_length;
        got.timed_out     = result_i.timed_out;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %p", $time, got);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("byte_position", want.byte_position, got.byte_position);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("frame_length", want.frame_length, got.frame_length);
          check_field("timed_out", want.timed_out, got.timed_out);
        end
      end

      // Settings writes, masked to the register widths.
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgTimeout:     gap_limit    = cfg_i.data[9:0];
          CfgFirstStart:  start_nom[0] = cfg_i.data[8:0];
          CfgSecondStart: start_nom[1] = cfg_i.data[8:0];
          CfgThirdStart:  start_nom[2] = cfg_i.data[8:0];
          CfgFourthStart: start_nom[3] = cfg_i.data[8:0];
          CfgLongPulse:   long_limit   = cfg_i.data[9:0];
          default: ;
        endcase
      end

      if (line_i.valid && line_i.ready) begin
        if (decode_edge(line_i.line_level, line_i.interval_ticks, want)) begin
          expected_words.push_back(want);
        end
      end

      pending_o    <= expected_words.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== bench/manchester_pulse_width_receiver_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the Manchester pulse-width receiver: clock, reset, line edge and
// settings stimulus, result back-pressure and the verdict. Depends on mpwr_pkg, mpwr_if,
// the receiver RTL and mpwr_frame_checker.

module manchester_pulse_width_receiver_top_tb;
  import mpwr_pkg::*;

  localparam int unsigned ItemTarget  = 1400;
  localparam int unsigned PhaseItems  = 160;
  localparam int unsigned SettleTicks = 4;
  localparam int unsigned TailTicks   = 8;
  localparam int unsigned CycleLimit  = 500000;

  logic clk_i;
  logic rst_ni;

  mpwr_edge_if   line_ch ();
  mpwr_cfg_if    cfg_ch ();
  mpwr_result_if res_ch ();

  int unsigned pending;
  int unsigned fail_count;

  // Settings as last written, used to shape well-formed frames.
  int unsigned timeout_set = 200;
  int unsigned nominal_set [4] = '{80, 80, 40, 40};
  int unsigned long_set = 20;

  int unsigned edges_sent = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          long_only = 1'b0;

  manchester_pulse_width_receiver_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .edge_i   (line_ch),
    .cfg_i    (cfg_ch),
    .result_o (res_ch)
  );

  mpwr_frame_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_i       (line_ch),
    .cfg_i        (cfg_ch),
    .result_i     (res_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall before each word, none while calm.
  initial begin : result_pacing
    int unsigned pause;
    forever begin
      pause = calm ? 0 : $urandom_range(0, 5);
      if (pause != 0) begin
        res_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Offers one edge word after a random gap and waits until it is taken.
  task automatic send_edge(input logic level, input int unsigned ticks);
    int unsigned pause;
    pause = calm ? 0 : $urandom_range(0, 5);
    if (pause != 0) begin
      line_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    line_ch.valid          <= 1'b1;
    line_ch.line_level     <= level;
    line_ch.interval_ticks <= ticks[TicksW-1:0];
    do @(posedge clk_i); while (!line_ch.ready);
    edges_sent++;
  endtask

  // Waits until every predicted word has arrived and the pipeline is empty.
  task automatic drain(input int unsigned tail);
    line_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned to, input int unsigned n1,
                                input int unsigned n2, input int unsigned n3,
                                input int unsigned n4, input int unsigned lp);
    int unsigned        vals [6];
    logic [CfgIdxW-1:0] regs [6];
    vals = '{to, n1, n2, n3, n4, lp};
    regs = '{CfgTimeout, CfgFirstStart, CfgSecondStart, CfgThirdStart, CfgFourthStart,
             CfgLongPulse};
    drain(SettleTicks);
    for (int k = 0; k < 6; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[k];
      cfg_ch.data  <= vals[k][CfgDataW-1:0];
      do @(posedge clk_i); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    timeout_set = to;
    nominal_set = '{n1, n2, n3, n4};
    long_set    = lp;
  endtask

  // A low edge with this width would restart the preamble.
  function automatic bit hits_restart(int unsigned ticks);
    return ticks > nominal_set[0] && ticks < 2 * nominal_set[0];
  endfunction

  function automatic int unsigned window_ticks(int unsigned nominal, int unsigned cap);
    int unsigned hi;
    hi = 2 * nominal - 1;
    if (hi > cap) hi = cap;
    return $urandom_range(nominal + 1, hi);
  endfunction

  // A preamble can pass only if every window is open and the last three lie below the timeout.
  function automatic bit frame_ok();
    if (nominal_set[0] < 2) return 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (nominal_set[k] < 2 || nominal_set[k] + 1 > timeout_set) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Up to six preamble edges: idle high, four timed pulses, then the sync edge.
  task automatic send_preamble(input int unsigned stages);
    int unsigned ticks;
    if (stages > 0) send_edge(1'b1, $urandom_range(0, 1023));
    if (stages > 1) send_edge(1'b0, window_ticks(nominal_set[0], 1023));
    if (stages > 2) send_edge(1'b1, window_ticks(nominal_set[1], timeout_set));
    if (stages > 3) begin
      ticks = window_ticks(nominal_set[2], timeout_set);
      send_edge(hits_restart(ticks) ? 1'b1 : 1'b0, ticks);
    end
    if (stages > 4) send_edge(1'b1, window_ticks(nominal_set[3], timeout_set));
    if (stages > 5) begin
      ticks = $urandom_range(0, timeout_set);
      send_edge(hits_restart(ticks) ? 1'b1 : logic'($urandom_range(0, 1)), ticks);
    end
  endtask

  // One data bit as a long pulse or as a pair of short pulses.
  task automatic send_bit(input logic value);
    int unsigned ticks;
    int unsigned hi;
    bit          go_long;
    go_long = (long_set < timeout_set) && (long_only || $urandom_range(0, 1) == 1);
    if (go_long) begin
      ticks = $urandom_range(long_set + 1, timeout_set);
      for (int k = 0; k < 4 && !value && hits_restart(ticks); k++) begin
        ticks = $urandom_range(long_set + 1, timeout_set);
      end
      send_edge(value, ticks);
    end else begin
      hi    = (long_set < timeout_set) ? long_set : timeout_set;
      ticks = $urandom_range(0, hi);
      send_edge(hits_restart(ticks) ? 1'b1 : logic'($urandom_range(0, 1)), ticks);
      ticks = $urandom_range(0, hi);
      if (!value && hits_restart(ticks)) ticks = 0;
      send_edge(value, ticks);
    end
  endtask

  task automatic send_byte(input logic [7:0] data);
    for (int i = 0; i < 8; i++) send_bit(data[i]);
  endtask

  task automatic send_frame(input logic [7:0] first_byte, input int unsigned byte_count);
    send_preamble(6);
    for (int i = 0; i < byte_count; i++) begin
      send_byte(i == 0 ? first_byte : 8'($urandom_range(0, 255)));
    end
  endtask

  // A gap above the timeout, where the setting leaves room for one.
  task automatic send_gap();
    if (timeout_set < 1023) begin
      send_edge($urandom_range(0, 1), $urandom_range(timeout_set + 1, 1023));
    end
  endtask

  // Directed opening with the reset settings: window 81..159 for the first two
  // pulses, 41..79 for the last two, long pulses above 20, timeout above 200.
  task automatic run_opening();
    send_edge(1'b0, 0);      // low edge while idle does nothing
    send_edge(1'b1, 1023);   // idle high, no timeout check while idle
    send_edge(1'b0, 81);     // lowest first-window width
    send_edge(1'b0, 5);      // low edge while waiting for the second pulse
    send_edge(1'b1, 159);    // highest second-window width
    send_edge(1'b0, 1023);   // timeout inside the preamble
    send_edge(1'b1, 0);
    send_edge(1'b0, 120);
    send_edge(1'b1, 100);
    send_edge(1'b0, 41);
    send_edge(1'b1, 79);
    send_edge(1'b0, 0);      // sync edge, data follows
    send_edge(1'b1, 21);     // shortest long pulse
    send_edge(1'b0, 200);    // gap equal to the timeout is still data
    send_edge(1'b1, 20);     // short pair
    send_edge(1'b1, 0);
    send_edge(1'b0, 100);    // restart in the middle of a frame drops it
    send_edge(1'b1, 120);
    send_edge(1'b0, 60);
    send_edge(1'b1, 60);
    send_edge(1'b1, 0);
    send_edge(1'b1, 1023);   // timeout in the data phase with nothing stored
  endtask

  // One burst of traffic: mostly complete frames, otherwise cut frames and noise.
  task automatic run_burst();
    int unsigned pick;
    int unsigned first_byte;
    calm = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 9);
    if (!frame_ok() || pick == 9) begin
      repeat ($urandom_range(4, 20)) send_edge($urandom_range(0, 1), $urandom_range(0, 1023));
    end else if (pick == 8) begin
      send_preamble($urandom_range(1, 5));
      send_edge($urandom_range(0, 1), $urandom_range(0, 1023));
    end else if (pick >= 6) begin
      send_frame($urandom_range(0, 255), $urandom_range(0, 2));
      repeat ($urandom_range(0, 7)) send_bit($urandom_range(0, 1));
      send_gap();
    end else begin
      first_byte = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
      send_frame(first_byte, first_byte + 3);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    rst_ni                 <= 1'b0;
    line_ch.valid          <= 1'b0;
    line_ch.line_level     <= 1'b0;
    line_ch.interval_ticks <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= '0;
    cfg_ch.data            <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_opening();

    for (int ph = 0; edges_sent < ItemTarget; ph++) begin
      case (ph)
        0: apply_settings(1023, 511, 511, 511, 511, 1023);
        1: apply_settings(0, 0, 0, 0, 0, 0);
        2: begin
          // Reset values again, with one frame that overruns the store.
          apply_settings(200, 80, 80, 40, 40, 20);
          long_only = 1'b1;
          send_frame($urandom_range(62, 255), MaxFrameBytes + 2);
          long_only = 1'b0;
          send_gap();
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            apply_settings($urandom_range(0, 1023), $urandom_range(0, 511),
                           $urandom_range(0, 511), $urandom_range(0, 511),
                           $urandom_range(0, 511), $urandom_range(0, 1023));
          end else begin
            apply_settings($urandom_range(240, 1023), $urandom_range(2, 120),
                           $urandom_range(2, 120), $urandom_range(2, 120),
                           $urandom_range(2, 120), $urandom_range(0, 150));
          end
        end
      endcase
      phase_end = edges_sent + PhaseItems;
      while (edges_sent < phase_end) run_burst();
    end

    drain(TailTicks);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
